@@ src/rlbp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types of the range list to bitmap parser.
// No dependencies; every other file of the block but rlbp_out_if imports it.
package rlbp_pkg;

  // Default number of elements in the membership map
  localparam int unsigned SET_SIZE_DEF = 256;

  // Fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned QUERY_W = 8;

  // Action codes
  localparam logic ACT_CHAR  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Characters of the list syntax
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Phase of the token being read
  typedef enum logic [2:0] {
    PH_NUM  = 3'b001,  // single number or range begin, no dot yet
    PH_SKIP = 3'b010,  // right after the dot, next character is skipped
    PH_END  = 3'b100   // reading the range end
  } phase_e;

endpackage

@@ src/rlbp_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the parser: valid/ready handshake with one character or query item.
// Depends on rlbp_pkg for field widths.
interface rlbp_in_if import rlbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAR_W-1:0] character;
  logic              string_end;
  logic [QUERY_W-1:0] query_index;

  modport source (output valid, action, character, string_end, query_index, input ready);
  modport sink   (input valid, action, character, string_end, query_index, output ready);
endinterface

@@ src/rlbp_out_if.sv @@
`timescale 1ns / 1ps
// Output channel of the parser: valid/ready handshake carrying one membership answer.
// Standalone, no package needed.
interface rlbp_out_if ();
  logic valid;
  logic ready;
  logic is_member;

  modport source (output valid, is_member, input ready);
  modport sink   (input valid, is_member, output ready);
endinterface

@@ src/rlbp_close.sv @@
`timescale 1ns / 1ps
// Token closer: turns a finished token into the mask of elements it marks.
// Depends on rlbp_pkg for the phase type.
module rlbp_close import rlbp_pkg::*; #(
  parameter int unsigned  SET_SIZE = SET_SIZE_DEF,
  localparam int unsigned VAL_W    = $clog2(SET_SIZE + 1)
) (
  input  logic                en_i,
  input  phase_e              phase_i,
  input  logic [VAL_W-1:0]    begin_i,
  input  logic [VAL_W-1:0]    value_i,
  output logic [SET_SIZE-1:0] mask_o
);

  logic [VAL_W-1:0] first;
  logic [VAL_W-1:0] last;

  // A lone number is a one-element range; a token cut off after its dot ends at 0
  always_comb begin
    case (phase_i)
      PH_NUM: begin
        first = value_i;
        last  = value_i;
      end
      PH_SKIP: begin
        first = begin_i;
        last  = '0;
      end
      PH_END: begin
        first = begin_i;
        last  = value_i;
      end
      default: begin
        first = value_i;
        last  = value_i;
      end
    endcase
  end

  // Elements beyond the map simply have no bit, which clips the range
  always_comb begin
    for (int unsigned i = 0; i < SET_SIZE; i++) begin
      mask_o[i] = en_i && (VAL_W'(i) >= first) && (VAL_W'(i) <= last);
    end
  end

endmodule

@@ src/range_list_to_bitmap_parser_core.sv @@
`timescale 1ns / 1ps
// Top level of the range list to bitmap parser: input register, parse logic, result register.
// Depends on rlbp_pkg, rlbp_in_if, rlbp_out_if and rlbp_close.
// A query answer is held in the input register and then in the result register, where it is offered.
// Throughput: one item per cycle, characters and queries alike, unless a query stalls as below;
//   all the parsing for an item is combinational between the input register and the map.
// Stalls: a query waits only while the result register holds an untaken answer, and any item
//   behind it waits with it; a character never waits on its own account.
// Reset (rst_ni low, asynchronous): map cleared, token state cleared, next character
//   starts a new string, both registers empty.
module range_list_to_bitmap_parser_core import rlbp_pkg::*; #(
  parameter int unsigned SET_SIZE = SET_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlbp_in_if.sink    in_i,
  rlbp_out_if.source out_o
);

  localparam int unsigned VAL_W = $clog2(SET_SIZE + 1);
  localparam int unsigned IDX_W = $clog2(SET_SIZE);
  localparam int unsigned CMP_W = ((IDX_W > QUERY_W) ? IDX_W : QUERY_W) + 1;
  localparam int unsigned PRD_W = VAL_W + 4;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               in_vld_q, in_vld_d;
  logic               in_act_q;
  logic [CHAR_W-1:0]  in_char_q;
  logic               in_end_q;
  logic [QUERY_W-1:0] in_qidx_q;

  logic out_vld_q, out_vld_d;
  logic out_mem_q, out_mem_d;

  logic out_free;
  logic advance;
  logic accept;
  logic do_char;
  logic do_query;

  // The result register is free when empty or being emptied this cycle
  assign out_free = !out_vld_q || out_o.ready;
  // A character leaves no result, so only a query waits for the result register
  assign advance  = in_vld_q && ((in_act_q == ACT_CHAR) || out_free);
  assign do_char  = advance && (in_act_q == ACT_CHAR);
  assign do_query = advance && (in_act_q == ACT_QUERY);

  assign in_i.ready = !in_vld_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload needs no reset; load only on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_act_q  <= in_i.action;
      in_char_q <= in_i.character;
      in_end_q  <= in_i.string_end;
      in_qidx_q <= in_i.query_index;
    end
  end

  // ---------------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------------
  logic [SET_SIZE-1:0] map_q, map_d;
  logic [VAL_W-1:0]    cur_q, cur_d;
  logic                inv_q, inv_d;
  logic [VAL_W-1:0]    beg_q, beg_d;
  phase_e              phase_q, phase_d;
  logic                new_str_q, new_str_d;

  // State at the start of this character: a new string starts from a clean token
  logic [VAL_W-1:0] cur_s0, beg_s0;
  logic             inv_s0;
  phase_e           phase_s0;
  logic [VAL_W-1:0] num_s0;

  // State after the character itself, before a string end closes the token
  logic [VAL_W-1:0] cur_s1, beg_s1;
  logic             inv_s1;
  phase_e           phase_s1;
  logic [VAL_W-1:0] num_s1;

  logic             is_space, is_comma, is_dot, is_digit;
  logic [PRD_W-1:0] prod;
  logic [VAL_W-1:0] digit_val;

  logic [SET_SIZE-1:0] comma_mask;
  logic [SET_SIZE-1:0] end_mask;

  assign is_space = (in_char_q == CH_SPACE);
  assign is_comma = (in_char_q == CH_COMMA);
  assign is_dot   = (in_char_q == CH_DOT);
  assign is_digit = (in_char_q >= CH_ZERO) && (in_char_q <= CH_NINE);

  always_comb begin
    if (new_str_q) begin
      cur_s0   = '0;
      inv_s0   = 1'b0;
      beg_s0   = '0;
      phase_s0 = PH_NUM;
    end else begin
      cur_s0   = cur_q;
      inv_s0   = inv_q;
      beg_s0   = beg_q;
      phase_s0 = phase_q;
    end
  end

  // A number that met a non-digit counts as zero
  assign num_s0 = inv_s0 ? '0 : cur_s0;

  // Decimal accumulate: value * 10 + digit, saturating one past the last element
  assign prod = PRD_W'({cur_s0, 3'b000}) + PRD_W'({cur_s0, 1'b0})
              + PRD_W'(in_char_q[3:0]);
  assign digit_val = (prod > PRD_W'(SET_SIZE)) ? VAL_W'(SET_SIZE) : prod[VAL_W-1:0];

  always_comb begin
    cur_s1   = cur_s0;
    inv_s1   = inv_s0;
    beg_s1   = beg_s0;
    phase_s1 = phase_s0;
    if (is_space) begin
      // ignore spaces everywhere
    end else if (is_comma) begin
      // close the token and start a clean one
      cur_s1   = '0;
      inv_s1   = 1'b0;
      beg_s1   = '0;
      phase_s1 = PH_NUM;
    end else if (phase_s0 == PH_SKIP) begin
      phase_s1 = PH_END;
    end else if ((phase_s0 == PH_NUM) && is_dot) begin
      beg_s1   = num_s0;
      cur_s1   = '0;
      inv_s1   = 1'b0;
      phase_s1 = PH_SKIP;
    end else if (is_digit) begin
      cur_s1 = digit_val;
    end else begin
      inv_s1 = 1'b1;
    end
  end

  assign num_s1 = inv_s1 ? '0 : cur_s1;

  // Comma closes the running token
  rlbp_close #(
    .SET_SIZE (SET_SIZE)
  ) u_close_comma (
    .en_i    (is_comma),
    .phase_i (phase_s0),
    .begin_i (beg_s0),
    .value_i (num_s0),
    .mask_o  (comma_mask)
  );

  // String end closes whatever is left, an empty token after a comma included
  rlbp_close #(
    .SET_SIZE (SET_SIZE)
  ) u_close_end (
    .en_i    (in_end_q),
    .phase_i (phase_s1),
    .begin_i (beg_s1),
    .value_i (num_s1),
    .mask_o  (end_mask)
  );

  always_comb begin
    map_d     = map_q;
    cur_d     = cur_q;
    inv_d     = inv_q;
    beg_d     = beg_q;
    phase_d   = phase_q;
    new_str_d = new_str_q;
    if (do_char) begin
      map_d     = (new_str_q ? '0 : map_q) | comma_mask | end_mask;
      new_str_d = in_end_q;
      if (in_end_q) begin
        cur_d   = '0;
        inv_d   = 1'b0;
        beg_d   = '0;
        phase_d = PH_NUM;
      end else begin
        cur_d   = cur_s1;
        inv_d   = inv_s1;
        beg_d   = beg_s1;
        phase_d = phase_s1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q     <= '0;
      cur_q     <= '0;
      inv_q     <= 1'b0;
      beg_q     <= '0;
      phase_q   <= PH_NUM;
      new_str_q <= 1'b1;
    end else begin
      map_q     <= map_d;
      cur_q     <= cur_d;
      inv_q     <= inv_d;
      beg_q     <= beg_d;
      phase_q   <= phase_d;
      new_str_q <= new_str_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Query and result register
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] qidx_ext;
  logic             q_in_range;
  logic             q_bit;

  // Answer from the map as built by all earlier characters; beyond the map read zero
  assign qidx_ext   = CMP_W'(in_qidx_q);
  assign q_in_range = (qidx_ext < CMP_W'(SET_SIZE));
  assign q_bit      = q_in_range && map_q[qidx_ext[IDX_W-1:0]];

  always_comb begin
    out_vld_d = out_vld_q;
    out_mem_d = out_mem_q;
    if (do_query) begin
      out_vld_d = 1'b1;
      out_mem_d = q_bit;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mem_q <= out_mem_d;
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.is_member = out_mem_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A query that advances always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_query |=> out_vld_q)
    else $error("query advanced without a result");

  // A character whose result slot was just taken leaves the result register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_char && out_vld_q && out_o.ready) |=> !out_vld_q)
    else $error("character produced a result");

  // A held input item keeps its action while it waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_act_q)))
    else $error("waiting input item lost or changed");

  // String end leaves a clean token and arms the map clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_char && in_end_q) |=> (new_str_q && (phase_q == PH_NUM) && (cur_q == '0)))
    else $error("string end did not reset the token");

  // Queries never disturb the parse state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!do_char) |=> ($stable(map_q) && $stable(new_str_q) && $stable(phase_q)))
    else $error("parse state moved without a character");

endmodule
